// ----- src/fbdu_pkg.sv -----
`timescale 1ns / 1ps
// fbdu_pkg: shared types and constants of the delta unpacker
package fbdu_pkg;

    // field widths of the item and result beats
    localparam int CMD_W    = 1;
    localparam int BYTE_W   = 8;
    localparam int WIDTH_W  = 6;
    localparam int COUNT_W  = 11;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 2;

    // bit buffer: up to 31 held bits plus one new byte
    localparam int ACC_W  = 40;
    localparam int HELD_W = 6;

    // command codes
    localparam logic [CMD_W-1:0] CMD_START = 1'b0;
    localparam logic [CMD_W-1:0] CMD_BYTE  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_HEADER = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_BLOCK   = 2'd2;

    // input beat
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [BYTE_W-1:0]  data_byte;
        logic [WIDTH_W-1:0] bits_per_value;
        logic [COUNT_W-1:0] block_count;
        logic [VALUE_W-1:0] base_value;
    } fbdu_in_t;

    // result beat
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [POS_W-1:0]    position;
        logic                last;
        logic [STATUS_W-1:0] status;
    } fbdu_out_t;

    // classified operation kinds queued from front to back
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BAD   = 2'd1,
        OP_BYTE  = 2'd2
    } fbdu_kind_t;

    // queued operation
    typedef struct packed {
        fbdu_kind_t         kind;
        logic [BYTE_W-1:0]  data_byte;
        logic [WIDTH_W-1:0] bits_per_value;
        logic [COUNT_W-1:0] block_count;
        logic [VALUE_W-1:0] base_value;
    } fbdu_op_t;

endpackage

// ----- src/fbdu_front.sv -----
`timescale 1ns / 1ps
// fbdu_front: accepts item beats and classifies them for the back end
module fbdu_front #(
    parameter int MAX_BLOCK  = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic               item_valid,
    output logic               item_ready,
    input  fbdu_pkg::fbdu_in_t item,
    input  logic               q_full,
    output logic               push,
    output fbdu_pkg::fbdu_op_t push_op
);
    import fbdu_pkg::*;

    logic bad_header;

    // header check against the configured limits
    assign bad_header = (item.bits_per_value == '0)
                     || (32'(item.bits_per_value) > 32'(VALUE_BITS))
                     || (item.block_count == '0)
                     || (32'(item.block_count) > 32'(MAX_BLOCK));

    // take a beat whenever the queue has room
    assign item_ready = !q_full;
    assign push       = item_valid && !q_full;

    // classify
    always_comb
    begin
        push_op.data_byte      = item.data_byte;
        push_op.bits_per_value = item.bits_per_value;
        push_op.block_count    = item.block_count;
        push_op.base_value     = item.base_value;
        if (item.command == CMD_BYTE)
        begin
            push_op.kind = OP_BYTE;
        end
        else if (bad_header)
        begin
            push_op.kind = OP_BAD;
        end
        else
        begin
            push_op.kind = OP_START;
        end
    end

endmodule

// ----- src/fbdu_queue.sv -----
`timescale 1ns / 1ps
// fbdu_queue: short fifo of classified operations between front and back
module fbdu_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  fbdu_pkg::fbdu_op_t push_op,
    output logic               q_full,
    output logic               q_valid,
    output fbdu_pkg::fbdu_op_t head,
    input  logic               pop
);
    import fbdu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fbdu_op_t          entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = entries_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ----- src/fbdu_back.sv -----
`timescale 1ns / 1ps
// fbdu_back: runs queued operations, unpacks deltas and emits running sums
module fbdu_back #(
    parameter int MAX_BLOCK  = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  fbdu_pkg::fbdu_op_t  head,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_ready,
    output fbdu_pkg::fbdu_out_t result
);
    import fbdu_pkg::*;

    localparam int LEFT_W = $clog2(MAX_BLOCK + 1);

    typedef enum logic [1:0] {
        ST_IDLE    = 2'b01,
        ST_EXTRACT = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [HELD_W-1:0]      held_reg, held_next;
    logic [VALUE_BITS-1:0]  sum_reg, sum_next;
    logic [LEFT_W-1:0]      left_reg, left_next;
    logic [POS_W-1:0]       emitted_reg, emitted_next;
    logic [WIDTH_W-1:0]     width_reg, width_next;
    logic                   out_valid_reg, out_valid_next;
    fbdu_out_t              out_reg, out_next;

    logic                   slot_free;
    logic                   can_extract;
    logic [HELD_W-1:0]      rest;
    logic [ACC_W-1:0]       shifted;
    logic [ACC_W-1:0]       keep_mask;
    logic [VALUE_BITS-1:0]  sum_add;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // output slot is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || result_ready;

    // delta extraction from the top of the held bits
    assign can_extract = (left_reg != '0) && (held_reg >= width_reg);
    assign rest        = held_reg - width_reg;
    assign shifted     = acc_reg >> rest;
    assign keep_mask   = (ACC_W'(1) << rest) - ACC_W'(1);
    assign sum_add     = sum_reg + shifted[VALUE_BITS-1:0];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        held_next      = held_reg;
        sum_next       = sum_reg;
        left_next      = left_reg;
        emitted_next   = emitted_reg;
        width_next     = width_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        pop            = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    pop = 1'b1;
                    unique case (head.kind)
                        OP_START:
                        begin
                            acc_next     = '0;
                            held_next    = '0;
                            emitted_next = '0;
                            width_next   = head.bits_per_value;
                            left_next    = LEFT_W'(head.block_count);
                            sum_next     = head.base_value[VALUE_BITS-1:0];
                        end
                        OP_BAD:
                        begin
                            acc_next       = '0;
                            held_next      = '0;
                            left_next      = '0;
                            emitted_next   = '0;
                            out_valid_next = 1'b1;
                            out_next       = '{value: '0, position: '0, last: 1'b0,
                                               status: STATUS_BAD_HEADER};
                        end
                        OP_BYTE:
                        begin
                            if (left_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_next       = '{value: '0, position: '0, last: 1'b0,
                                                   status: STATUS_NO_BLOCK};
                            end
                            else
                            begin
                                acc_next   = {acc_reg[ACC_W-BYTE_W-1:0], head.data_byte};
                                held_next  = held_reg + HELD_W'(BYTE_W);
                                state_next = ST_EXTRACT;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_EXTRACT:
            begin
                if (can_extract)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = '{value: VALUE_W'(sum_add), position: emitted_reg,
                                           last: (left_reg == LEFT_W'(1)),
                                           status: STATUS_OK};
                        sum_next       = sum_add;
                        held_next      = rest;
                        acc_next       = acc_reg & keep_mask;
                        left_next      = left_reg - LEFT_W'(1);
                        emitted_next   = emitted_reg + POS_W'(1);
                    end
                end
                else
                begin
                    // drop padding once the block is done
                    if (left_reg == '0)
                    begin
                        acc_next  = '0;
                        held_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            held_reg      <= '0;
            sum_reg       <= '0;
            left_reg      <= '0;
            emitted_reg   <= '0;
            width_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            held_reg      <= held_next;
            sum_reg       <= sum_next;
            left_reg      <= left_next;
            emitted_reg   <= emitted_next;
            width_reg     <= width_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// ----- src/for_block_delta_unpacker_top.sv -----
`timescale 1ns / 1ps
// for_block_delta_unpacker_top: frame-of-reference delta block decoder
//
//   channel  handshake                    payload
//   item     item_valid / item_ready      item   (fbdu_in_t)
//   result   result_valid / result_ready  result (fbdu_out_t)
//
// a start beat loads the block header; a byte beat gives k decoded values (up to 8 at
// width 1), one value per cycle from the extract loop while results are taken
// a byte outside a block or a bad header gives one error beat
// a 4-entry operation queue lets items be taken while the back end works or stalls
// reset clears the bit buffer, running sum and counters; no clearing pass
module for_block_delta_unpacker_top #(
    parameter int MAX_BLOCK  = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  fbdu_pkg::fbdu_in_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output fbdu_pkg::fbdu_out_t result
);
    import fbdu_pkg::*;

    logic     q_full;
    logic     q_valid;
    logic     push;
    logic     pop;
    fbdu_op_t push_op;
    fbdu_op_t head;

    // classify incoming beats
    fbdu_front #(
        .MAX_BLOCK  (MAX_BLOCK),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_full     (q_full),
        .push       (push),
        .push_op    (push_op)
    );

    // decoupling queue
    fbdu_queue #(
        .DEPTH (4)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .q_full  (q_full),
        .q_valid (q_valid),
        .head    (head),
        .pop     (pop)
    );

    // unpack and accumulate
    fbdu_back #(
        .MAX_BLOCK  (MAX_BLOCK),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ----- src/fbdu_checker.sv -----
`timescale 1ns / 1ps
// fbdu_checker: port-level checks of the delta unpacker, bound to the top level
module fbdu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_ready,
    input fbdu_pkg::fbdu_out_t result
);
    import fbdu_pkg::*;

    // a stalled result beat stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat withdrawn while stalled");

    // a stalled result beat keeps its payload
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result payload changed while stalled");

    // error beats carry an empty payload
    a_error_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != STATUS_OK)
        |-> (result.value == '0) && (result.position == '0) && !result.last)
        else $error("error beat with nonzero payload");

    // only defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status == STATUS_OK)
                      || (result.status == STATUS_BAD_HEADER)
                      || (result.status == STATUS_NO_BLOCK))
        else $error("undefined status code");

    // a value following a non-last value in the same block sits one position later
    a_position_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && (result.status == STATUS_OK) && !result.last
        ##1 result_valid && (result.status == STATUS_OK)
        |-> (result.position == $past(result.position) + 10'd1))
        else $error("position did not advance by one");

endmodule

bind for_block_delta_unpacker_top fbdu_checker u_checker (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking randomized bench for the frame-of-reference delta unpacker
module testbench;
    import fbdu_pkg::*;

    localparam int MAX_DELTAS   = 1024;
    localparam int SUM_BITS     = 32;
    localparam int MAX_GAP      = 18;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 40;
    localparam int LIMIT_CYCLES = 500000;
    localparam int RANDOM_ITEMS = 150;
    localparam int MAX_PRINTS   = 40;
    localparam logic [ACC_W-1:0] ACC_ONE = 1;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    fbdu_in_t  item;
    logic      result_valid;
    logic      result_ready;
    fbdu_out_t result;

    // decoder state mirrored by the bench
    logic [ACC_W-1:0]   held_stream   = '0;
    logic [HELD_W-1:0]  held_count    = '0;
    logic [VALUE_W-1:0] sum_now       = '0;
    logic [COUNT_W-1:0] deltas_left   = '0;
    logic [POS_W-1:0]   next_position = '0;
    logic [WIDTH_W-1:0] delta_width   = '0;

    fbdu_out_t expected_values[$];
    int        mismatches  = 0;
    int        items_sent  = 0;
    int        cycle_count = 0;
    bit        src_idle     = 1'b0;
    bit        sink_idle    = 1'b0;
    bit        hold_pending = 1'b0;

    for_block_delta_unpacker_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // expected result beats for one accepted item beat
    task automatic unpack_expected(input fbdu_in_t beat);
        fbdu_out_t          r;
        int                 produced;
        int                 rest;
        logic [ACC_W-1:0]   field_mask;
        logic [ACC_W-1:0]   delta_bits;
        produced = 0;
        r = '0;
        if (beat.command == CMD_START)
        begin
            // any running block is dropped
            held_stream   = '0;
            held_count    = '0;
            deltas_left   = '0;
            next_position = '0;
            if (beat.bits_per_value == 0 || beat.bits_per_value > SUM_BITS ||
                beat.block_count == 0 || beat.block_count > MAX_DELTAS)
            begin
                r.status = STATUS_BAD_HEADER;
                expected_values.insert(expected_values.size(), r);
            end
            else
            begin
                delta_width = beat.bits_per_value;
                deltas_left = beat.block_count;
                sum_now     = beat.base_value;
            end
        end
        else if (deltas_left == 0)
        begin
            r.status = STATUS_NO_BLOCK;
            expected_values.insert(expected_values.size(), r);
        end
        else
        begin
            held_stream = {held_stream[ACC_W-BYTE_W-1:0], beat.data_byte};
            held_count  = held_count + HELD_W'(BYTE_W);
            // peel off complete deltas, msb first
            while (deltas_left != 0 && delta_width != 0 &&
                   held_count >= delta_width && produced < BYTE_W)
            begin
                rest       = held_count - delta_width;
                field_mask = (ACC_ONE << delta_width) - ACC_ONE;
                delta_bits = (held_stream >> rest) & field_mask;
                sum_now    = sum_now + delta_bits[VALUE_W-1:0];
                r.value    = sum_now;
                r.position = next_position;
                r.last     = (deltas_left == 1);
                r.status   = STATUS_OK;
                expected_values.insert(expected_values.size(), r);
                produced++;
                held_count    = rest;
                held_stream   = held_stream & ((ACC_ONE << rest) - ACC_ONE);
                deltas_left   = deltas_left - 1;
                next_position = next_position + 1;
            end
            // padding after the final delta is dropped
            if (deltas_left == 0)
            begin
                held_stream = '0;
                held_count  = '0;
            end
        end
    endtask

    task automatic check_value(input fbdu_out_t got);
        fbdu_out_t want;
        if (expected_values.size() == 0)
            report_mismatch($sformatf("result with nothing pending: value %h status %0d",
                                      got.value, got.status));
        else
        begin
            want = expected_values.pop_front();
            if (got.value !== want.value)
                report_mismatch($sformatf("value got %h want %h at position %0d",
                                          got.value, want.value, want.position));
            if (got.position !== want.position)
                report_mismatch($sformatf("position got %0d want %0d",
                                          got.position, want.position));
            if (got.last !== want.last)
                report_mismatch($sformatf("last got %b want %b at position %0d",
                                          got.last, want.last, want.position));
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d",
                                          got.status, want.status));
        end
    endtask

    // one item beat; entered and left at a rising edge
    task automatic send_item(input fbdu_in_t beat);
        int gap;
        bit taken;
        gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        do
        begin
            @(negedge clk);
            taken = (item_ready === 1'b1);
            if (taken)
                unpack_expected(beat);
            @(posedge clk);
        end
        while (!taken);
        items_sent++;
    endtask

    function automatic fbdu_in_t start_beat(input logic [WIDTH_W-1:0] w,
                                            input logic [COUNT_W-1:0] c,
                                            input logic [VALUE_W-1:0] base);
        fbdu_in_t b;
        b.command        = CMD_START;
        b.data_byte      = $urandom_range(0, 255);
        b.bits_per_value = w;
        b.block_count    = c;
        b.base_value     = base;
        return b;
    endfunction

    function automatic fbdu_in_t byte_beat(input logic [BYTE_W-1:0] d);
        fbdu_in_t b;
        b.command        = CMD_BYTE;
        b.data_byte      = d;
        b.bits_per_value = $urandom_range(0, (1 << WIDTH_W) - 1);
        b.block_count    = $urandom_range(0, (1 << COUNT_W) - 1);
        b.base_value     = $urandom();
        return b;
    endfunction

    function automatic fbdu_in_t bad_header_beat();
        logic [WIDTH_W-1:0] w;
        logic [COUNT_W-1:0] c;
        w = $urandom_range(1, SUM_BITS);
        c = $urandom_range(1, MAX_DELTAS);
        case ($urandom_range(0, 3))
            0:       w = '0;
            1:       w = $urandom_range(SUM_BITS + 1, (1 << WIDTH_W) - 1);
            2:       c = '0;
            default: c = $urandom_range(MAX_DELTAS + 1, (1 << COUNT_W) - 1);
        endcase
        return start_beat(w, c, $urandom());
    endfunction

    function automatic int bytes_for(input int w, input int c);
        return (w * c + BYTE_W - 1) / BYTE_W;
    endfunction

    // start beat followed by random packed bytes
    task automatic send_block(input int w, input int c, input int byte_total);
        send_item(start_beat(w, c, $urandom()));
        repeat (byte_total) send_item(byte_beat($urandom_range(0, 255)));
    endtask

    // stop offering and let every pending result come out
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (expected_values.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed_cases();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        // width 1: one byte gives eight values
        send_item(start_beat(1, 8, '0));
        send_item(byte_beat(8'hA5));
        // byte after the block has ended
        send_item(byte_beat(8'hFF));
        // full width deltas, running sum wraps
        send_item(start_beat(SUM_BITS, 2, 32'hFFFF_FFF0));
        repeat (3) send_item(byte_beat(8'h00));
        send_item(byte_beat(8'h20));
        repeat (4) send_item(byte_beat(8'hFF));
        // padding bits after the last value, then a stray byte
        send_item(start_beat(3, 2, 32'd100));
        send_item(byte_beat(8'b101_011_11));
        send_item(byte_beat(8'h00));
        // rejected headers: width and count out of range
        send_item(start_beat(0, 5, $urandom()));
        send_item(start_beat(SUM_BITS + 1, 1, $urandom()));
        send_item(start_beat((1 << WIDTH_W) - 1, (1 << COUNT_W) - 1, $urandom()));
        send_item(start_beat(5, 0, $urandom()));
        send_item(start_beat(1, MAX_DELTAS + 1, $urandom()));
        // block abandoned mid-delta by a new start
        send_item(start_beat(12, 3, 32'd7));
        send_item(byte_beat(8'hAB));
        send_item(start_beat(5, 1, 32'd1));
        send_item(byte_beat(8'hF8));
        wait_drained();
    endtask

    task automatic test_full_block();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        // largest block, position runs up to its top
        send_block(1, MAX_DELTAS, bytes_for(1, MAX_DELTAS));
        wait_drained();
    endtask

    task automatic test_output_stall();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        // sink holds off after the next beat while items keep coming
        hold_pending = 1'b1;
        send_item(bad_header_beat());
        send_block(1, 64, bytes_for(1, 64));
        send_block(7, 20, bytes_for(7, 20));
        wait_drained();
    endtask

    task automatic test_random_blocks();
        int       first;
        int       pick;
        int       w;
        int       c;
        int       need;
        logic [63:0] raw;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            w = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8)
                                              : $urandom_range(9, SUM_BITS);
            c = (w <= 8) ? $urandom_range(1, 40) : $urandom_range(1, 10);
            need = bytes_for(w, c);
            if (pick < 70)
                send_block(w, c, need);
            else if (pick < 80)
                send_block(w, c, $urandom_range(0, need - 1));
            else if (pick < 88)
                send_block(w, c, need + $urandom_range(1, 2));
            else if (pick < 96)
                send_item(bad_header_beat());
            else
            begin
                // any field pattern at all
                raw = {$urandom(), $urandom()};
                send_item(raw[$bits(fbdu_in_t)-1:0]);
            end
        end
        wait_drained();
    endtask

    // result sink with random and long stalls
    initial
    begin : result_sink
        int gap;
        bit taken;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_pending)
            begin
                gap = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (gap != 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
            begin
                @(negedge clk);
                taken = (result_valid === 1'b1);
                if (taken)
                    check_value(result);
                @(posedge clk);
            end
            while (!taken);
        end
    end

    // reset, tests in turn, verdict
    initial
    begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_full_block();
        test_output_stall();
        test_random_blocks();
        if (mismatches == 0 && expected_values.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
